>>> hw/rtl/tsae_pkg.sv
// ----------------------------------------------------------------------------
// Tape stop effect package
// Shared sizes, fixed point constants, register indexes and the command
// struct that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package tsae_pkg;

	// sample store
	localparam int STORE_DEPTH = 131072;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int WPOS_W      = ADDR_W + 1;          // holds STORE_DEPTH itself

	// oversampled taps per frame, a power of two
	localparam int TAPS_LOG2   = 5;
	localparam int TAPS        = 1 << TAPS_LOG2;
	localparam int TAP_CNT_W   = (TAPS_LOG2 > 0) ? TAPS_LOG2 : 1;

	// fixed point
	localparam int SAMPLE_W    = 24;
	localparam int FRAC_W      = 32;
	localparam int SPEED_W     = FRAC_W + 1;          // Q1.32
	localparam int RPOS_W      = ADDR_W + FRAC_W;     // integer.fraction read position
	localparam int ACC_W       = SAMPLE_W + TAPS_LOG2;
	localparam int PROD_W      = ACC_W + SPEED_W;
	localparam int AVG_SHIFT   = FRAC_W + TAPS_LOG2;

	localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(64'd1 << FRAC_W);

	// decay = DECAY_BASE + round(DECAY_SPAN * (65535 - knob) / 65535)
	// with DECAY_SPAN = DECAY_SPAN_Q * 65535 + DECAY_SPAN_R
	localparam int KNOB_W                  = 16;
	localparam logic [31:0] DECAY_BASE     = 32'd4294537799;
	localparam logic [18:0] DECAY_SPAN_Q   = 19'd5;
	localparam logic [31:0] DECAY_SPAN_R   = 32'd58872;
	localparam logic [31:0] KNOB_HALF      = 32'd32767;
	localparam logic [16:0] KNOB_MAX       = 17'd65535;
	localparam logic [KNOB_W-1:0] SPEED_SETTING_RST = 16'd32768;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_SPEED_SETTING = 1'b0,
		CFG_FADE_ENABLE   = 1'b1
	} cfg_idx_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture input frame
		logic bypass;    // pass frame, reset speed and positions
		logic store_wr;  // record frame, clear accumulators
		logic tap_rd;    // read one tap, advance read position
		logic mul;       // scale sums by gain
		logic avg;       // divide and saturate
		logic dec_lo;    // decay, low half partial product
		logic dec_hi;    // decay, high half and speed update
		logic out_ld;    // load output register
	} dp_cmd_t;

endpackage

>>> hw/rtl/tsae_cfg.sv
// ----------------------------------------------------------------------------
// Tape stop configuration registers
// Holds the speed knob and fade switch and derives the Q0.32 decay factor.
// ----------------------------------------------------------------------------
module tsae_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  tsae_pkg::cfg_idx_t            wr_index,
	input  logic [15:0]                   wr_data,
	output logic                          fade_enable,
	output logic [31:0]                   decay
);

	logic [tsae_pkg::KNOB_W-1:0] speed_setting_q;
	logic                        fade_q;
	logic [31:0]                 decay_q;

	logic [15:0] inv;
	logic [31:0] y;
	logic [15:0] q0;
	logic [16:0] r0;
	logic [1:0]  corr;
	logic [18:0] quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_setting_q <= tsae_pkg::SPEED_SETTING_RST;
			fade_q          <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				tsae_pkg::CFG_SPEED_SETTING: speed_setting_q <= wr_data;
				tsae_pkg::CFG_FADE_ENABLE:   fade_q          <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Divide by 65535: estimate with the high half, then fix the remainder
	// y - q0*65535 = y[15:0] + q0, which stays at or below twice the divisor.
	always_comb begin
		inv  = ~speed_setting_q;
		y    = 32'(32'(inv) * tsae_pkg::DECAY_SPAN_R) + tsae_pkg::KNOB_HALF;
		q0   = y[31:16];
		r0   = 17'(y[15:0]) + 17'(q0);
		if (r0 >= 17'(2 * tsae_pkg::KNOB_MAX))
			corr = 2'd2;
		else if (r0 >= tsae_pkg::KNOB_MAX)
			corr = 2'd1;
		else
			corr = 2'd0;
		quot = 19'(19'(inv) * tsae_pkg::DECAY_SPAN_Q) + 19'(q0) + 19'(corr);
	end

	always_ff @(posedge clk) begin
		decay_q <= tsae_pkg::DECAY_BASE + 32'(quot);
	end

	assign fade_enable = fade_q;
	assign decay       = decay_q;

endmodule

>>> hw/rtl/tsae_ctrl.sv
// ----------------------------------------------------------------------------
// Tape stop controller
// Sequences one frame at a time, either through bypass or through record,
// tap reads, gain, average and decay, and owns the output valid flag.
// ----------------------------------------------------------------------------
module tsae_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_stop,
	output logic              out_valid,
	input  logic              out_ready,
	output tsae_pkg::dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BYPASS,
		ST_WRITE,
		ST_TAP,
		ST_DRAIN,
		ST_MUL,
		ST_AVG,
		ST_DEC_LO,
		ST_DEC_HI,
		ST_DONE
	} state_t;

	localparam logic [tsae_pkg::TAP_CNT_W-1:0] TAP_LAST =
		tsae_pkg::TAP_CNT_W'(tsae_pkg::TAPS - 1);

	state_t                          state_q;
	logic [tsae_pkg::TAP_CNT_W-1:0]  tap_cnt_q;
	logic                            out_valid_q;
	logic                            accept;
	logic                            out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= in_stop ? ST_WRITE : ST_BYPASS;
				end
				ST_BYPASS: state_q <= ST_DONE;
				ST_WRITE: begin
					tap_cnt_q <= '0;
					state_q   <= ST_TAP;
				end
				ST_TAP: begin
					if (tap_cnt_q == TAP_LAST)
						state_q <= ST_DRAIN;
					else
						tap_cnt_q <= tap_cnt_q + 1'b1;
				end
				ST_DRAIN:  state_q <= ST_MUL;
				ST_MUL:    state_q <= ST_AVG;
				ST_AVG:    state_q <= ST_DEC_LO;
				ST_DEC_LO: state_q <= ST_DEC_HI;
				ST_DEC_HI: state_q <= ST_DONE;
				ST_DONE: begin
					// hold until the output register frees up
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.load = accept;
		unique case (state_q)
			ST_BYPASS: cmd.bypass   = 1'b1;
			ST_WRITE:  cmd.store_wr = 1'b1;
			ST_TAP:    cmd.tap_rd   = 1'b1;
			ST_MUL:    cmd.mul      = 1'b1;
			ST_AVG:    cmd.avg      = 1'b1;
			ST_DEC_LO: cmd.dec_lo   = 1'b1;
			ST_DEC_HI: cmd.dec_hi   = 1'b1;
			ST_DONE:   cmd.out_ld   = out_free;
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/tsae_dp.sv
// ----------------------------------------------------------------------------
// Tape stop datapath
// Sample stores, write and read positions, tap accumulators, gain and
// average, play speed with its decay multiplier, and the output register.
// ----------------------------------------------------------------------------
module tsae_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tsae_pkg::dp_cmd_t                   cmd,
	input  logic signed [tsae_pkg::SAMPLE_W-1:0] in_left,
	input  logic signed [tsae_pkg::SAMPLE_W-1:0] in_right,
	input  logic                                fade_enable,
	input  logic [31:0]                         decay,
	output logic signed [tsae_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [tsae_pkg::SAMPLE_W-1:0] out_right
);

	localparam int SW = tsae_pkg::SAMPLE_W;
	localparam int PW = tsae_pkg::PROD_W;
	localparam int RW = tsae_pkg::RPOS_W + 1;

	localparam logic [RW-1:0] RPOS_LIMIT =
		RW'({tsae_pkg::ADDR_W'(tsae_pkg::STORE_DEPTH - 1), tsae_pkg::FRAC_W'(0)});
	localparam logic [tsae_pkg::WPOS_W-1:0] WPOS_FULL =
		tsae_pkg::WPOS_W'(tsae_pkg::STORE_DEPTH);
	localparam logic signed [PW-1:0] AVG_BIAS =
		PW'((64'd1 << tsae_pkg::AVG_SHIFT) - 64'd1);
	localparam logic signed [PW-1:0] SAT_MAX = PW'((64'd1 << (SW - 1)) - 64'd1);
	localparam logic signed [PW-1:0] SAT_MIN = -PW'(64'd1 << (SW - 1));

	logic signed [SW-1:0] left_mem  [tsae_pkg::STORE_DEPTH];
	logic signed [SW-1:0] right_mem [tsae_pkg::STORE_DEPTH];

	logic signed [SW-1:0]                 in_l_q, in_r_q;
	logic [tsae_pkg::WPOS_W-1:0]          wr_pos_q;
	logic [tsae_pkg::RPOS_W-1:0]          rd_pos_q;
	logic [tsae_pkg::SPEED_W-1:0]         speed_q;
	logic                                 rd_vld_s1;
	logic signed [SW-1:0]                 rd_l_s1, rd_r_s1;
	logic signed [tsae_pkg::ACC_W-1:0]    acc_l_q, acc_r_q;
	logic signed [PW-1:0]                 prod_l_q, prod_r_q;
	logic signed [SW-1:0]                 res_l_q, res_r_q;
	logic signed [SW-1:0]                 out_l_q, out_r_q;
	logic [31:0]                          dec_part_q;

	logic [tsae_pkg::ADDR_W-1:0]          rd_addr;
	logic [RW-1:0]                        rd_next;
	logic                                 gain_one;
	logic signed [PW-1:0]                 gain_frac;
	logic signed [PW-1:0]                 prod_l, prod_r;
	logic [16:0]                          dec_a;
	logic [48:0]                          dec_m;
	logic [49:0]                          dec_sum;

	function automatic logic signed [SW-1:0] avg_sat(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] b;
		logic signed [PW-1:0] q;
		b = p + (p[PW-1] ? AVG_BIAS : '0);   // truncate toward zero
		q = b >>> tsae_pkg::AVG_SHIFT;
		if (q > SAT_MAX)
			q = SAT_MAX;
		else if (q < SAT_MIN)
			q = SAT_MIN;
		return q[SW-1:0];
	endfunction

	assign rd_addr   = rd_pos_q[tsae_pkg::RPOS_W-1:tsae_pkg::FRAC_W];
	assign rd_next   = RW'(rd_pos_q) + RW'(speed_q >> tsae_pkg::TAPS_LOG2);
	assign gain_one  = !fade_enable || speed_q[tsae_pkg::FRAC_W];
	assign gain_frac = PW'($signed({1'b0, speed_q[tsae_pkg::FRAC_W-1:0]}));

	always_comb begin
		if (gain_one) begin
			prod_l = PW'(acc_l_q) <<< tsae_pkg::FRAC_W;
			prod_r = PW'(acc_r_q) <<< tsae_pkg::FRAC_W;
		end else begin
			prod_l = PW'(acc_l_q) * gain_frac;
			prod_r = PW'(acc_r_q) * gain_frac;
		end
	end

	// one 17x32 multiplier serves both halves of the decay product
	assign dec_a   = cmd.dec_hi ? speed_q[tsae_pkg::SPEED_W-1:16] : {1'b0, speed_q[15:0]};
	assign dec_m   = 49'(dec_a) * 49'(decay);
	assign dec_sum = 50'(dec_m) + 50'(dec_part_q);

	always_ff @(posedge clk) begin
		if (cmd.store_wr && (wr_pos_q < WPOS_FULL)) begin
			left_mem[wr_pos_q[tsae_pkg::ADDR_W-1:0]]  <= in_l_q;
			right_mem[wr_pos_q[tsae_pkg::ADDR_W-1:0]] <= in_r_q;
		end
		if (cmd.tap_rd) begin
			rd_l_s1 <= left_mem[rd_addr];
			rd_r_s1 <= right_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q  <= '0;
			rd_pos_q  <= '0;
			speed_q   <= tsae_pkg::SPEED_ONE;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.tap_rd;
			if (cmd.bypass) begin
				wr_pos_q <= '0;
				rd_pos_q <= '0;
				speed_q  <= tsae_pkg::SPEED_ONE;
			end
			if (cmd.store_wr && (wr_pos_q < WPOS_FULL))
				wr_pos_q <= wr_pos_q + 1'b1;
			if (cmd.tap_rd) begin
				// saturate at the last entry
				if (rd_next > RPOS_LIMIT)
					rd_pos_q <= RPOS_LIMIT[tsae_pkg::RPOS_W-1:0];
				else
					rd_pos_q <= rd_next[tsae_pkg::RPOS_W-1:0];
			end
			if (cmd.dec_hi)
				speed_q <= dec_sum[16 +: tsae_pkg::SPEED_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_l_q <= in_left;
			in_r_q <= in_right;
		end
		if (cmd.store_wr) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (rd_vld_s1) begin
			acc_l_q <= acc_l_q + tsae_pkg::ACC_W'(rd_l_s1);
			acc_r_q <= acc_r_q + tsae_pkg::ACC_W'(rd_r_s1);
		end
		if (cmd.mul) begin
			prod_l_q <= prod_l;
			prod_r_q <= prod_r;
		end
		if (cmd.bypass) begin
			res_l_q <= in_l_q;
			res_r_q <= in_r_q;
		end else if (cmd.avg) begin
			res_l_q <= avg_sat(prod_l_q);
			res_r_q <= avg_sat(prod_r_q);
		end
		if (cmd.dec_lo)
			dec_part_q <= dec_m[47:16];
		if (cmd.out_ld) begin
			out_l_q <= res_l_q;
			out_r_q <= res_r_q;
		end
	end

	assign out_left  = out_l_q;
	assign out_right = out_r_q;

endmodule

>>> hw/rtl/tape_stop_audio_effect.sv
// ----------------------------------------------------------------------------
// Tape stop audio effect
// Stereo 24-bit frames in and out; with stop engaged, the frames are
// recorded and played back at a decaying speed with optional fade.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  --------  -----------------  ------------------------------------------
//  s_        s_tvalid/s_tready  s_tdata: left_sample, right_sample
//                               s_tuser: stop_active
//  m_        m_tvalid/m_tready  m_tdata: left_out, right_out
//  cfg_      cfg_valid/ready    cfg_index (0 speed_setting, 1 fade_enable),
//                               cfg_data
//
//  A frame with stop engaged goes from transaction to the next s_tready
//  through the store write, one store read per tap through a single
//  read port, then gain, average and two decay multiply steps.
//  A bypass frame skips the store. The output register lets a new frame
//  in while a result waits on m_tready; only the final load stalls.
//  arst_n clears control state; cfg_ready is always high.
//
module tape_stop_audio_effect (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,    // [23:0] left_sample, [47:24] right_sample
	input  logic [0:0]  s_tuser,    // [0] stop_active
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // [23:0] left_out, [47:24] right_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tsae_pkg::dp_cmd_t                      cmd;
	logic                                   fade_enable;
	logic [31:0]                            decay;
	logic signed [tsae_pkg::SAMPLE_W-1:0]   out_left;
	logic signed [tsae_pkg::SAMPLE_W-1:0]   out_right;

	assign cfg_ready = 1'b1;

	tsae_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (cfg_valid && cfg_ready),
		.wr_index    (tsae_pkg::cfg_idx_t'(cfg_index)),
		.wr_data     (cfg_data),
		.fade_enable (fade_enable),
		.decay       (decay)
	);

	tsae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_stop   (s_tuser[0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	tsae_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_left     (s_tdata[23:0]),
		.in_right    (s_tdata[47:24]),
		.fade_enable (fade_enable),
		.decay       (decay),
		.out_left    (out_left),
		.out_right   (out_right)
	);

	assign m_tdata = {out_right, out_left};

	// one frame in flight: no second transaction right after the first
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a frame is in flight");

	// a result is only loaded while the controller is busy with a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("output loaded without a frame in flight");

	// bypass frame into an empty output appears unchanged after the input, result and output registers
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] && !m_tvalid
		|-> ##3 m_tvalid && (m_tdata == $past(s_tdata, 3)))
		else $error("bypass frame altered or late");

endmodule
